/* design/fdm_pkg.sv */
// Shared types and codes for the floored divide / modulo unit.
// No dependencies; compile first.
`default_nettype none

package fdm_pkg;

    localparam int DEF_WIDTH = 32;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic OP_QUOT = 1'b0;
    localparam logic OP_MOD  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_8    = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16   = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_WIDE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd3;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic              sx;
        logic              sy;
        logic              dz;
    } t_meta;

endpackage

`default_nettype wire

/* design/fdm_req_if.sv */
// Request channel of the floored divide / modulo unit.
// Depends on fdm_pkg for field widths.
`default_nettype none

interface fdm_req_if
    import fdm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SIZE_W-1:0] operand_size;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;

    modport source (output valid, req_type, operand_size, dividend, divisor, input ready);
    modport sink   (input valid, req_type, operand_size, dividend, divisor, output ready);
endinterface

`default_nettype wire

/* design/fdm_rsp_if.sv */
// Response channel of the floored divide / modulo unit.
// Depends on fdm_pkg for field widths.
`default_nettype none

interface fdm_rsp_if
    import fdm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   quotient_or_remainder;
    logic [STATUS_W-1:0] status;

    modport source (output valid, quotient_or_remainder, status, input ready);
    modport sink   (input valid, quotient_or_remainder, status, output ready);
endinterface

`default_nettype wire

/* design/floored_divide_modulo_unit.sv */
// Pipelined floored signed divide / modulo, one restoring step per stage.
// Depends on fdm_pkg, fdm_req_if and fdm_rsp_if.
//
// Usage:
//   i_req carries one word per request: req_type (0 quotient, 1 modulo),
//   operand_size (0 8-bit, 1 16-bit, 2 or 3 wide), dividend and divisor.
//   o_rsp returns one word per request in request order: the floored
//   quotient or modulo, sign-extended to 32 bits, and a status
//   (0 ok, 1 divide by zero with result 0, 2 quotient overflow wrapped).
//   Wide operands are WIDTH bits, clipped to 8..32.
//
//   A request passes these registered stages, with
//   DW = max(wide width, 16): one operand stage (sign extend, magnitude),
//   DW quotient-bit stages of one subtract each, one sign fixup stage and
//   the output register.
//   Throughput is one word per cycle while the output is not stalled; the
//   stage count is set by the one-bit-per-stage subtract chain.
//   When the receiver stalls with a word waiting, the whole pipe holds and
//   i_req.ready drops; nothing is lost or repeated.
//   Synchronous reset clears all stage valid bits; the pipe is empty after.
`default_nettype none

module floored_divide_modulo_unit
    import fdm_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fdm_req_if.sink    i_req,
    fdm_rsp_if.source  o_rsp
);

    localparam int WB = (WIDTH > 32) ? 32 : ((WIDTH < 8) ? 8 : WIDTH);
    localparam int DW = (WB < 16) ? 16 : WB;

    logic          w_en;

    logic          r_v    [0:DW];
    t_meta         r_meta [0:DW];
    logic [DW-1:0] r_rem  [0:DW];
    logic [DW-1:0] r_nq   [0:DW];
    logic [DW-1:0] r_d    [0:DW];

    logic          n_v    [0:DW];
    t_meta         n_meta [0:DW];
    logic [DW-1:0] n_rem  [0:DW];
    logic [DW-1:0] n_nq   [0:DW];
    logic [DW-1:0] n_d    [0:DW];

    logic          r_fx_v;
    t_meta         r_fx_meta;
    logic [DW:0]   r_fx_q;
    logic [DW-1:0] r_fx_rmag;
    logic          r_fx_rneg;
    logic          n_fx_v;
    t_meta         n_fx_meta;
    logic [DW:0]   n_fx_q;
    logic [DW-1:0] n_fx_rmag;
    logic          n_fx_rneg;

    logic                r_out_v;
    logic [DATA_W-1:0]   r_out_res;
    logic [STATUS_W-1:0] r_out_st;
    logic                n_out_v;
    logic [DATA_W-1:0]   n_out_res;
    logic [STATUS_W-1:0] n_out_st;

    function automatic logic [DATA_W-1:0] sext_out(logic [DW:0] v, logic [SIZE_W-1:0] size);
        case (size)
            SIZE_8:  sext_out = DATA_W'(signed'(v[7:0]));
            SIZE_16: sext_out = DATA_W'(signed'(v[15:0]));
            default: sext_out = DATA_W'(signed'(v[WB-1:0]));
        endcase
    endfunction

    function automatic logic fits(logic [DW:0] v, logic [SIZE_W-1:0] size);
        case (size)
            SIZE_8:  fits = (v == (DW+1)'(signed'(v[7:0])));
            SIZE_16: fits = (v == (DW+1)'(signed'(v[15:0])));
            default: fits = (v == (DW+1)'(signed'(v[WB-1:0])));
        endcase
    endfunction

    assign w_en        = !r_out_v || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.quotient_or_remainder = r_out_res;
    assign o_rsp.status = r_out_st;

    // operand stage and quotient-bit stages
    always_comb begin
        logic [DW-1:0] x_ext;
        logic [DW-1:0] y_ext;
        logic [DW:0]   shift_val;
        logic [DW:0]   shift_diff;
        case (i_req.operand_size)
            SIZE_8: begin
                x_ext = DW'(signed'(i_req.dividend[7:0]));
                y_ext = DW'(signed'(i_req.divisor[7:0]));
            end
            SIZE_16: begin
                x_ext = DW'(signed'(i_req.dividend[15:0]));
                y_ext = DW'(signed'(i_req.divisor[15:0]));
            end
            default: begin
                x_ext = DW'(signed'(i_req.dividend[WB-1:0]));
                y_ext = DW'(signed'(i_req.divisor[WB-1:0]));
            end
        endcase
        n_v[0]         = i_req.valid;
        n_meta[0].op   = i_req.req_type;
        n_meta[0].size = i_req.operand_size;
        n_meta[0].sx   = x_ext[DW-1];
        n_meta[0].sy   = y_ext[DW-1];
        n_meta[0].dz   = (y_ext == '0);
        n_rem[0]       = '0;
        n_nq[0]        = x_ext[DW-1] ? (~x_ext + DW'(1)) : x_ext;
        n_d[0]         = y_ext[DW-1] ? (~y_ext + DW'(1)) : y_ext;
        shift_val  = '0;
        shift_diff = '0;
        for (int k = 1; k <= DW; k++) begin
            shift_val  = {r_rem[k-1], r_nq[k-1][DW-1]};
            shift_diff = shift_val - {1'b0, r_d[k-1]};
            n_v[k]     = r_v[k-1];
            n_meta[k]  = r_meta[k-1];
            n_d[k]     = r_d[k-1];
            n_rem[k]   = shift_diff[DW] ? shift_val[DW-1:0] : shift_diff[DW-1:0];
            n_nq[k]    = {r_nq[k-1][DW-2:0], !shift_diff[DW]};
        end
    end

    // sign fixup toward minus infinity
    always_comb begin
        logic neg_q;
        logic adj;
        neg_q     = r_meta[DW].sx ^ r_meta[DW].sy;
        adj       = neg_q && (r_rem[DW] != '0);
        n_fx_v    = r_v[DW];
        n_fx_meta = r_meta[DW];
        n_fx_q    = neg_q ? (~{1'b0, r_nq[DW]} + (DW+1)'(!adj)) : {1'b0, r_nq[DW]};
        n_fx_rmag = adj ? (r_d[DW] - r_rem[DW]) : r_rem[DW];
        n_fx_rneg = adj ? r_meta[DW].sy : r_meta[DW].sx;
    end

    // result select, size wrap and status
    always_comb begin
        logic [DW:0] mod_val;
        mod_val = r_fx_rneg ? (~{1'b0, r_fx_rmag} + (DW+1)'(1)) : {1'b0, r_fx_rmag};
        n_out_v = r_fx_v;
        if (r_fx_meta.dz) begin
            n_out_res = '0;
            n_out_st  = ST_DIV_ZERO;
        end else if (r_fx_meta.op == OP_QUOT) begin
            n_out_res = sext_out(r_fx_q, r_fx_meta.size);
            n_out_st  = fits(r_fx_q, r_fx_meta.size) ? ST_OK : ST_OVERFLOW;
        end else begin
            n_out_res = sext_out(mod_val, r_fx_meta.size);
            n_out_st  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_fx_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k <= DW; k++) begin
                r_v[k] <= n_v[k];
            end
            r_fx_v  <= n_fx_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= DW; k++) begin
                r_meta[k] <= n_meta[k];
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_d[k]    <= n_d[k];
            end
            r_fx_meta <= n_fx_meta;
            r_fx_q    <= n_fx_q;
            r_fx_rmag <= n_fx_rmag;
            r_fx_rneg <= n_fx_rneg;
            r_out_res <= n_out_res;
            r_out_st  <= n_out_st;
        end
    end

endmodule

`default_nettype wire

/* design/fdm_checker.sv */
// Port-level assertions for the floored divide / modulo unit, bound to the top level.
// Depends on fdm_pkg and floored_divide_modulo_unit.
`default_nettype none

module fdm_checker
    import fdm_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [DATA_W-1:0]   i_out_res,
    input wire [STATUS_W-1:0] i_out_st
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_res) && $stable(i_out_st))
        else $error("stalled result word changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request stalled with empty output");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_st == ST_DIV_ZERO |-> i_out_res == '0)
        else $error("divide by zero with nonzero result");

    a_st_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_st != ST_UNUSED)
        else $error("unused status code");

    a_ovf_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_st == ST_OVERFLOW |-> i_out_res[DATA_W-1])
        else $error("overflow result not most negative");

endmodule

bind floored_divide_modulo_unit fdm_checker u_fdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_res   (o_rsp.quotient_or_remainder),
    .i_out_st    (o_rsp.status)
);

`default_nettype wire

/* tb/floored_divide_modulo_unit_tb.sv */
// Testbench for floored_divide_modulo_unit: random and directed divide requests
// are checked against a floored quotient/modulo predictor.
// Depends on fdm_pkg, fdm_req_if, fdm_rsp_if and the unit itself.
`timescale 1ns / 1ps

module floored_divide_modulo_unit_tb;
    import fdm_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RANDOM_WORDS   = 1925;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 60;
    localparam int TIMEOUT_NS     = 4_000_000;
    localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;

    typedef struct {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } t_div_result;

    class divide_scoreboard;
        t_div_result pending_results[$];
        int          errors;

        function automatic longint sign_extend(logic [63:0] v, int unsigned w);
            logic [63:0] mask;
            mask = (64'd1 << w) - 64'd1;
            v = v & mask;
            if (v[w-1])
                return longint'(v) - longint'(64'd1 << w);
            return longint'(v);
        endfunction

        function automatic void note_request(logic op, logic [SIZE_W-1:0] sz,
                                             logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            int unsigned w;
            longint      x, y, q, r, lim, res;
            t_div_result e;
            w = (sz == SIZE_8) ? 8 : (sz == SIZE_16) ? 16 : 32;
            x = sign_extend(64'(a), w);
            y = sign_extend(64'(b), w);
            e.status = ST_OK;
            if (y == 0) begin
                e.value  = '0;
                e.status = ST_DIV_ZERO;
            end else begin
                q = x / y;
                r = x % y;
                if (r != 0 && ((r < 0) != (y < 0))) begin
                    q = q - 1;
                    r = r + y;
                end
                if (op == OP_QUOT) begin
                    lim = longint'(64'd1 << (w - 1));
                    if (q >= lim || q < -lim)
                        e.status = ST_OVERFLOW;
                    res = q;
                end else begin
                    res = r;
                end
                e.value = DATA_W'(sign_extend(64'(res), w));
            end
            pending_results.push_back(e);
        endfunction

        function automatic void check_response(logic [DATA_W-1:0] value,
                                               logic [STATUS_W-1:0] status);
            t_div_result e;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected word value=%0d status=%0d",
                             $signed(value), status);
                return;
            end
            e = pending_results.pop_front();
            if (value !== e.value || status !== e.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                             $signed(e.value), e.status, $signed(value), status);
            end
        endfunction

        function automatic int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_gaps;
    bit   rsp_holdoff;
    divide_scoreboard sb;

    fdm_req_if req_if ();
    fdm_rsp_if rsp_if ();

    floored_divide_modulo_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.req_type, req_if.operand_size,
                                req_if.dividend, req_if.divisor);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.quotient_or_remainder, rsp_if.status);
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return $urandom_range(1, 3);
        if (k < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned size_bits(logic [SIZE_W-1:0] sz);
        return (sz == SIZE_8) ? 8 : (sz == SIZE_16) ? 16 : 32;
    endfunction

    function automatic logic [DATA_W-1:0] size_mask(logic [SIZE_W-1:0] sz);
        return (size_bits(sz) == 32) ? '1 : (32'd1 << size_bits(sz)) - 32'd1;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand(logic [SIZE_W-1:0] sz);
        logic [DATA_W-1:0] mask, most_neg, v;
        int                k;
        mask     = size_mask(sz);
        most_neg = 32'd1 << (size_bits(sz) - 1);
        k        = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 20);
            6:          v = ~32'($urandom_range(0, 19));
            7:          v = most_neg;
            8:          v = most_neg - 32'd1;
            default:    v = $urandom_range(0, 1) ? mask : 32'd1;
        endcase
        return ($urandom & ~mask) | (v & mask);
    endfunction

    task automatic send_word(input logic op, input logic [SIZE_W-1:0] sz,
                             input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        @(negedge i_clk);
        req_if.valid        = 1'b1;
        req_if.req_type     = op;
        req_if.operand_size = sz;
        req_if.dividend     = a;
        req_if.divisor      = b;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic sender_gap();
        int n;
        if (no_gaps || $urandom_range(0, 9) < 6)
            return;
        n = pick_gap();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic [SIZE_W-1:0] sz;
        logic [DATA_W-1:0] a, b, mask;
        int                k;
        k = $urandom_range(0, 9);
        sz = (k < 3) ? SIZE_8 : (k < 6) ? SIZE_16 : (k < 9) ? SIZE_WIDE : SIZE_SPARE;
        mask = size_mask(sz);
        a = pick_operand(sz);
        b = pick_operand(sz);
        k = $urandom_range(0, 19);
        if (k == 0) begin
            b = $urandom & ~mask;
        end else if (k == 1) begin
            a = ($urandom & ~mask) | (32'd1 << (size_bits(sz) - 1));
            b = $urandom | mask;
        end
        send_word($urandom_range(0, 1) ? OP_MOD : OP_QUOT, sz, a, b);
    endtask

    initial begin
        int run;
        run = 0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rsp_holdoff) begin
                rsp_holdoff  = 1'b0;
                rsp_if.ready = 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
                run = 0;
            end else if (run > 0) begin
                run--;
            end else if (no_gaps || $urandom_range(0, 9) < 6) begin
                rsp_if.ready = 1'b1;
                run = $urandom_range(0, 7);
            end else begin
                rsp_if.ready = 1'b0;
                run = pick_gap() - 1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        sb                  = new;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        no_gaps             = 1'b1;
        rsp_holdoff         = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = OP_QUOT;
        req_if.operand_size = SIZE_8;
        req_if.dividend     = '0;
        req_if.divisor      = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // most negative over minus one, each size
        send_word(OP_QUOT, SIZE_8,     32'h0000_0080, 32'h0000_00FF);
        send_word(OP_MOD,  SIZE_8,     32'hFFFF_FF80, 32'hFFFF_FFFF);
        send_word(OP_QUOT, SIZE_16,    32'h1234_8000, 32'hABCD_FFFF);
        send_word(OP_MOD,  SIZE_16,    32'h0000_8000, 32'h0000_FFFF);
        send_word(OP_QUOT, SIZE_WIDE,  32'h8000_0000, 32'hFFFF_FFFF);
        send_word(OP_MOD,  SIZE_WIDE,  32'h8000_0000, 32'hFFFF_FFFF);
        send_word(OP_QUOT, SIZE_SPARE, 32'h8000_0000, 32'hFFFF_FFFF);
        // zero divisor, including zero only in the low bits
        send_word(OP_QUOT, SIZE_WIDE,  32'h7FFF_FFFF, 32'h0000_0000);
        send_word(OP_MOD,  SIZE_WIDE,  32'h8000_0000, 32'h0000_0000);
        send_word(OP_QUOT, SIZE_8,     32'h0000_0005, 32'h1234_5600);
        send_word(OP_MOD,  SIZE_16,    32'hFFFF_FFFF, 32'hFFFF_0000);
        // sign combinations
        send_word(OP_QUOT, SIZE_WIDE,  32'd7,         32'hFFFF_FFFE);
        send_word(OP_MOD,  SIZE_WIDE,  32'd7,         32'hFFFF_FFFE);
        send_word(OP_QUOT, SIZE_WIDE,  32'hFFFF_FFF9, 32'd2);
        send_word(OP_MOD,  SIZE_WIDE,  32'hFFFF_FFF9, 32'd2);
        send_word(OP_MOD,  SIZE_WIDE,  32'hFFFF_FFF9, 32'hFFFF_FFFE);
        send_word(OP_QUOT, SIZE_8,     32'hABCD_EF7F, 32'h0000_0080);
        send_word(OP_MOD,  SIZE_8,     32'h5555_557F, 32'hFFFF_FF80);
        send_word(OP_QUOT, SIZE_16,    32'h0000_7FFF, 32'h0000_0001);
        send_word(OP_MOD,  SIZE_16,    32'h0000_8000, 32'h0000_7FFF);
        send_word(OP_QUOT, SIZE_WIDE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_MOD,  SIZE_WIDE,  32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_QUOT, SIZE_SPARE, 32'h8000_0000, 32'h8000_0000);
        send_word(OP_MOD,  SIZE_SPARE, 32'h0000_0003, 32'h0000_0005);
        wait_drained();

        no_gaps = 1'b0;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            no_gaps = ((i / 200) % 3 == 1);
            if (i == 450)
                rsp_holdoff = 1'b1;
            if (i == 1000)
                wait_drained();
            sender_gap();
            send_random_word();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
